[hw/rtl/c3s_pkg.sv]
// Shared types, constants and register codes for the 3x3 convolution stream block.
`timescale 1ns / 1ps

package c3s_pkg;

  // Defaults for the top-level parameters.
  localparam int DefMaxWidth  = 64;
  localparam int DefPixelBits = 16;

  // Fixed arithmetic and kernel geometry.
  localparam int FracBits   = 8;
  localparam int KSize      = 3;
  localparam int Taps       = KSize * KSize;
  localparam int QueueDepth = 4;

  // Register widths.
  localparam int WidthBits    = 7;
  localparam int HeightBits   = 10;
  localparam int CoefBits     = 48;
  localparam int CfgIndexBits = 3;
  localparam int CfgDataBits  = CoefBits;

  // Register reset values.
  localparam logic [WidthBits-1:0]  WidthReset  = WidthBits'(27);
  localparam logic [HeightBits-1:0] HeightReset = HeightBits'(48);

  typedef enum logic [CfgIndexBits-1:0] {
    CfgImageWidth  = 3'd0,
    CfgImageHeight = 3'd1,
    CfgCoefTop     = 3'd2,
    CfgCoefMid     = 3'd3,
    CfgCoefBot     = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [WidthBits-1:0]  image_width;
    logic [HeightBits-1:0] image_height;
  } geom_t;

  typedef struct packed {
    logic [CoefBits-1:0] bot;
    logic [CoefBits-1:0] mid;
    logic [CoefBits-1:0] top;
  } coef_regs_t;

  // Fill status of the window queue between front and back.
  typedef struct packed {
    logic empty;
    logic full;
    logic near_full;
  } q_stat_t;

endpackage

[hw/rtl/conv3x3_valid_stream.sv]
// Top level of the 3x3 valid-region convolution over a raster pixel stream.
//
//   Channel   Direction  Handshake                  Beat contents
//   pixel     in         push / full                pixel
//   result    out        pop / empty                conv_value, frame_last
//   config    in         cfg_write                  cfg_index, cfg_data
//
// One pixel is taken every cycle while full is low; a result passes from stage
// one through the window queue and the product register to the output register.
// The line buffer memory does one read and one write per pixel, which sets the
// rate at one pixel a cycle.
// Reset is synchronous; it clears counters, the window, the queue and the
// output valid flag. The line buffers and the output data are not cleared.
// When pop is held low the back part stops, the window queue fills, and full
// rises until the queue drains.
`timescale 1ns / 1ps

module conv3x3_valid_stream #(
  parameter int MAX_WIDTH  = c3s_pkg::DefMaxWidth,
  parameter int PIXEL_BITS = c3s_pkg::DefPixelBits
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [PIXEL_BITS-1:0]         pixel,
  input  logic                                 push,
  output logic                                 full,
  output logic signed [PIXEL_BITS-1:0]         conv_value,
  output logic                                 frame_last,
  output logic                                 empty,
  input  logic                                 pop,
  input  logic                                 cfg_write,
  input  logic [c3s_pkg::CfgIndexBits-1:0]     cfg_index,
  input  logic [c3s_pkg::CfgDataBits-1:0]      cfg_data
);
  import c3s_pkg::*;

  localparam int QWordW = Taps * PIXEL_BITS + 1;

  geom_t      geom;
  coef_regs_t coefs;

  logic              q_push;
  logic              q_pop;
  logic [QWordW-1:0] q_wr_data;
  logic [QWordW-1:0] q_rd_data;
  q_stat_t           q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.image_width  <= WidthReset;
      geom.image_height <= HeightReset;
      coefs             <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CfgImageWidth:  geom.image_width  <= cfg_data[WidthBits-1:0];
        CfgImageHeight: geom.image_height <= cfg_data[HeightBits-1:0];
        CfgCoefTop:     coefs.top         <= cfg_data[CoefBits-1:0];
        CfgCoefMid:     coefs.mid         <= cfg_data[CoefBits-1:0];
        CfgCoefBot:     coefs.bot         <= cfg_data[CoefBits-1:0];
        default:        ;
      endcase
    end
  end

  c3s_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .geom   (geom),
    .pixel  (pixel),
    .push   (push),
    .full   (full),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  c3s_queue #(
    .WIDTH (QWordW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .stat    (q_stat)
  );

  c3s_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .coefs      (coefs),
    .q_valid    (!q_stat.empty),
    .q_data     (q_rd_data),
    .q_pop      (q_pop),
    .conv_value (conv_value),
    .frame_last (frame_last),
    .empty      (empty),
    .pop        (pop)
  );

`ifndef ASSERT_OFF
  // The front must never push a window into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("window queue overflow");

  // The back must never take a window from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("window queue underflow");

  // An accepted pixel leaves at most one beat in stage one, so a near-full queue
  // with a pending push must hold the input off.
  a_room_for_pending: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !q_stat.full || !q_push)
    else $error("accepted pixel without queue room");
`endif

endmodule

[hw/rtl/c3s_queue.sv]
// Short queue of finished windows between the front and back parts.
`timescale 1ns / 1ps

module c3s_queue #(
  parameter int WIDTH = 145,
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [WIDTH-1:0]   wr_data,
  input  logic               rd_en,
  output logic [WIDTH-1:0]   rd_data,
  output c3s_pkg::q_stat_t   stat
);
  import c3s_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  assign rd_data        = slots[rd_ptr];
  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CntW'(DEPTH));
  assign stat.near_full = (count >= CntW'(DEPTH - 1));

endmodule

[hw/rtl/c3s_front.sv]
// Front part: pixel counters, line buffer memory, 3x3 window and result classification.
`timescale 1ns / 1ps

module c3s_front #(
  parameter int MAX_WIDTH  = c3s_pkg::DefMaxWidth,
  parameter int PIXEL_BITS = c3s_pkg::DefPixelBits
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  c3s_pkg::geom_t                                  geom,
  input  logic [PIXEL_BITS-1:0]                           pixel,
  input  logic                                            push,
  output logic                                            full,
  input  c3s_pkg::q_stat_t                                q_stat,
  output logic                                            q_push,
  output logic [c3s_pkg::Taps*PIXEL_BITS:0]               q_data
);
  import c3s_pkg::*;

  localparam int ColW   = $clog2(MAX_WIDTH);
  localparam int WCmpW  = ($clog2(MAX_WIDTH + 1) > WidthBits) ? $clog2(MAX_WIDTH + 1) : WidthBits;
  localparam int WordW  = 2 * PIXEL_BITS;

  logic [ColW-1:0]       col;
  logic [HeightBits-1:0] row;
  logic [WCmpW-1:0]      iw;
  logic [WCmpW-1:0]      w_eff;
  logic [HeightBits-1:0] h_eff;
  logic                  last_col;
  logic                  last_row;
  logic                  emit;
  logic                  accept;

  // Each line buffer word holds the previous row (high half) and the row before it.
  logic [WordW-1:0]      line_mem [MAX_WIDTH];
  logic [WordW-1:0]      rd_word;

  logic                  s1_valid;
  logic                  s1_emit;
  logic                  s1_last;
  logic [ColW-1:0]       s1_col;
  logic [PIXEL_BITS-1:0] s1_px;

  logic [PIXEL_BITS-1:0] win      [KSize][KSize];
  logic [PIXEL_BITS-1:0] win_next [KSize][KSize];

  always_comb begin
    iw = WCmpW'(geom.image_width);
    if (iw < WCmpW'(KSize)) begin
      w_eff = WCmpW'(KSize);
    end else if (iw > WCmpW'(MAX_WIDTH)) begin
      w_eff = WCmpW'(MAX_WIDTH);
    end else begin
      w_eff = iw;
    end
    if (geom.image_height < HeightBits'(KSize)) begin
      h_eff = HeightBits'(KSize);
    end else begin
      h_eff = geom.image_height;
    end
  end

  assign last_col = (WCmpW'(col) >= w_eff - WCmpW'(1));
  assign last_row = (row >= h_eff - HeightBits'(1));
  assign emit     = (col >= ColW'(KSize - 1)) && (row >= HeightBits'(KSize - 1));

  // A pixel in stage one may push in the cycle after its acceptance, so leave room for it.
  assign full   = s1_valid ? q_stat.near_full : q_stat.full;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : row + HeightBits'(1);
        end else begin
          col <= col + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px   <= pixel;
      s1_col  <= col;
      s1_emit <= emit;
      s1_last <= last_col && last_row;
    end
  end

  // Consecutive pixels never share a column, so the write back never meets a pending read.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word <= line_mem[col];
    end
    if (s1_valid) begin
      line_mem[s1_col] <= {s1_px, rd_word[WordW-1:PIXEL_BITS]};
    end
  end

  always_comb begin
    for (int m = 0; m < KSize; m++) begin
      for (int n = 0; n < KSize - 1; n++) begin
        win_next[m][n] = win[m][n+1];
      end
    end
    win_next[0][KSize-1] = rd_word[PIXEL_BITS-1:0];
    win_next[1][KSize-1] = rd_word[WordW-1:PIXEL_BITS];
    win_next[2][KSize-1] = s1_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < KSize; m++) begin
        for (int n = 0; n < KSize; n++) begin
          win[m][n] <= '0;
        end
      end
    end else if (s1_valid) begin
      win <= win_next;
    end
  end

  assign q_push = s1_valid && s1_emit;

  always_comb begin
    q_data[Taps*PIXEL_BITS] = s1_last;
    for (int m = 0; m < KSize; m++) begin
      for (int n = 0; n < KSize; n++) begin
        q_data[(m*KSize+n)*PIXEL_BITS +: PIXEL_BITS] = win_next[m][n];
      end
    end
  end

endmodule

[hw/rtl/c3s_back.sv]
// Back part: nine parallel products, the wrapped sum and the result register.
`timescale 1ns / 1ps

module c3s_back #(
  parameter int PIXEL_BITS = c3s_pkg::DefPixelBits
) (
  input  logic                                clk,
  input  logic                                rst,
  input  c3s_pkg::coef_regs_t                 coefs,
  input  logic                                q_valid,
  input  logic [c3s_pkg::Taps*PIXEL_BITS:0]   q_data,
  output logic                                q_pop,
  output logic signed [PIXEL_BITS-1:0]        conv_value,
  output logic                                frame_last,
  output logic                                empty,
  input  logic                                pop
);
  import c3s_pkg::*;

  // Coefficient bits beyond the register read as zero.
  localparam int PadW = (KSize * PIXEL_BITS > CoefBits) ? KSize * PIXEL_BITS : CoefBits;

  logic [PadW-1:0]                 row_pad [KSize];
  logic signed [PIXEL_BITS-1:0]    pix_s   [Taps];
  logic signed [PIXEL_BITS-1:0]    coef_s  [Taps];
  logic signed [2*PIXEL_BITS-1:0]  full_p  [Taps];
  logic [PIXEL_BITS-1:0]           prod_next [Taps];
  logic [PIXEL_BITS-1:0]           prod      [Taps];
  logic [PIXEL_BITS-1:0]           sum_next;

  logic m_valid;
  logic m_last;
  logic m_ready;
  logic out_valid;
  logic out_ready;

  assign row_pad[0] = PadW'(coefs.top);
  assign row_pad[1] = PadW'(coefs.mid);
  assign row_pad[2] = PadW'(coefs.bot);

  always_comb begin
    for (int m = 0; m < KSize; m++) begin
      for (int n = 0; n < KSize; n++) begin
        pix_s[m*KSize+n]  = q_data[(m*KSize+n)*PIXEL_BITS +: PIXEL_BITS];
        coef_s[m*KSize+n] = row_pad[m][n*PIXEL_BITS +: PIXEL_BITS];
      end
    end
    // Dropping the low fraction bits of a two's complement product floors it.
    for (int i = 0; i < Taps; i++) begin
      full_p[i]    = pix_s[i] * coef_s[i];
      prod_next[i] = full_p[i][FracBits+PIXEL_BITS-1:FracBits];
    end
  end

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < Taps; i++) begin
      sum_next = sum_next + prod[i];
    end
  end

  assign out_ready = !out_valid || pop;
  assign m_ready   = !m_valid || out_ready;
  assign q_pop     = q_valid && m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (m_ready) begin
        m_valid <= q_valid;
      end
      if (out_ready) begin
        out_valid <= m_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod   <= prod_next;
      m_last <= q_data[Taps*PIXEL_BITS];
    end
    if (m_valid && out_ready) begin
      conv_value <= sum_next;
      frame_last <= m_last;
    end
  end

  assign empty = !out_valid;

endmodule

[dv/conv3x3_valid_stream_checker.sv]
// Checker that predicts each 3x3 convolution result and compares it with the block's output.
`timescale 1ns / 1ps

module conv3x3_valid_stream_checker (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic signed [c3s_pkg::DefPixelBits-1:0]   pixel,
  input  logic                                      push,
  input  logic                                      full,
  input  logic signed [c3s_pkg::DefPixelBits-1:0]   conv_value,
  input  logic                                      frame_last,
  input  logic                                      empty,
  input  logic                                      pop,
  input  logic                                      cfg_write,
  input  logic [c3s_pkg::CfgIndexBits-1:0]          cfg_index,
  input  logic [c3s_pkg::CfgDataBits-1:0]           cfg_data,
  output int                                        errors,
  output int                                        pending
);

  import c3s_pkg::*;

  localparam int PixBits  = DefPixelBits;
  localparam int MaxWidth = DefMaxWidth;

  typedef logic signed [PixBits-1:0] pix_t;

  typedef struct packed {
    pix_t value;
    logic last;
  } conv_result_t;

  logic [WidthBits-1:0]  width_reg;
  logic [HeightBits-1:0] height_reg;
  logic [CoefBits-1:0]   coef_rows [KSize];
  pix_t                  prev_row  [MaxWidth];
  pix_t                  older_row [MaxWidth];
  pix_t                  win       [KSize][KSize];
  int                    col_cnt;
  int                    row_cnt;
  int                    fails = 0;
  conv_result_t          conv_expected [$];

  always @(posedge clk) begin : track
    int           w;
    int           h;
    int           col;
    int           row;
    bit           last_col;
    bit           last_row;
    pix_t         column_in [KSize];
    logic signed [2*PixBits-1:0] prod;
    logic [PixBits-1:0] acc;
    conv_result_t want;
    if (rst) begin
      width_reg  = WidthReset;
      height_reg = HeightReset;
      for (int r = 0; r < KSize; r++) begin
        coef_rows[r] = '0;
        for (int c = 0; c < KSize; c++) win[r][c] = '0;
      end
      for (int i = 0; i < MaxWidth; i++) begin
        prev_row[i]  = '0;
        older_row[i] = '0;
      end
      col_cnt = 0;
      row_cnt = 0;
      conv_expected.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CfgImageWidth:  width_reg    = cfg_data[WidthBits-1:0];
          CfgImageHeight: height_reg   = cfg_data[HeightBits-1:0];
          CfgCoefTop:     coef_rows[0] = cfg_data[CoefBits-1:0];
          CfgCoefMid:     coef_rows[1] = cfg_data[CoefBits-1:0];
          CfgCoefBot:     coef_rows[2] = cfg_data[CoefBits-1:0];
          default: ;
        endcase
      end

      // Results are checked before the new pixel is counted, so a result
      // that leaves in the same cycle as its own pixel is flagged.
      if (pop && !empty) begin
        if (conv_expected.size() == 0) begin
          $display("%0t: result beat %0d/%0b arrived with nothing expected",
                   $time, conv_value, frame_last);
          fails++;
        end else begin
          want = conv_expected.pop_front();
          if (conv_value !== want.value) begin
            $display("%0t: conv_value mismatch: expected %0d, actual %0d",
                     $time, want.value, conv_value);
            fails++;
          end
          if (frame_last !== want.last) begin
            $display("%0t: frame_last mismatch: expected %0b, actual %0b",
                     $time, want.last, frame_last);
            fails++;
          end
        end
      end

      if (push && !full) begin
        w = int'(width_reg);
        h = int'(height_reg);
        if (w < KSize) w = KSize;
        if (w > MaxWidth) w = MaxWidth;
        if (h < KSize) h = KSize;

        // A counter at or past a shrunken size ends the row or frame here.
        col      = col_cnt;
        row      = row_cnt;
        last_col = (col >= w - 1);
        last_row = (row >= h - 1);
        if (col >= MaxWidth) col = MaxWidth - 1;

        column_in[0] = older_row[col];
        column_in[1] = prev_row[col];
        column_in[2] = pixel;
        for (int r = 0; r < KSize; r++) begin
          win[r][0] = win[r][1];
          win[r][1] = win[r][2];
          win[r][2] = column_in[r];
        end
        older_row[col] = prev_row[col];
        prev_row[col]  = pixel;

        if (col >= 2 && row >= 2) begin
          acc = '0;
          for (int r = 0; r < KSize; r++) begin
            for (int c = 0; c < KSize; c++) begin
              prod = win[r][c] * pix_t'(coef_rows[r][c*PixBits +: PixBits]);
              // Dropping the low fraction bits floors the product; the sum wraps.
              acc = acc + prod[FracBits +: PixBits];
            end
          end
          want.value = pix_t'(acc);
          want.last  = last_col && last_row;
          conv_expected.push_back(want);
        end

        if (last_col) begin
          col_cnt = 0;
          row_cnt = last_row ? 0 : row + 1;
        end else begin
          col_cnt = col + 1;
        end
      end
    end
    errors  <= fails;
    pending <= conv_expected.size();
  end

endmodule

[dv/conv3x3_valid_stream_tb.sv]
// Top of the 3x3 convolution stream regression: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module conv3x3_valid_stream_tb;

  import c3s_pkg::*;

  localparam int PixBits     = DefPixelBits;
  localparam int LongHold    = 300;
  localparam int DrainCycles = 8;
  localparam int StallLimit  = 2000;
  localparam int RandomItems = 1250;

  typedef logic signed [PixBits-1:0] pix_t;

  localparam pix_t PixMin   = {1'b1, {(PixBits-1){1'b0}}};
  localparam pix_t PixMax   = {1'b0, {(PixBits-1){1'b1}}};
  localparam pix_t PixMinus = '1;
  localparam pix_t PixOne   = pix_t'(1);

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  pix_t                     pixel = '0;
  logic                     push = 1'b0;
  logic                     full;
  pix_t                     conv_value;
  logic                     frame_last;
  logic                     empty;
  logic                     pop = 1'b0;
  logic                     cfg_write = 1'b0;
  logic [CfgIndexBits-1:0]  cfg_index = '0;
  logic [CfgDataBits-1:0]   cfg_data = '0;
  int                       errors;
  int                       pending;

  logic calm = 1'b0;
  int   hold_asks = 0;
  int   hold_seen = 0;
  int   pop_hold = 0;
  int   results_seen = 0;
  int   pixels_sent = 0;
  int   quiet_cycles = 0;

  conv3x3_valid_stream dut (.*);

  conv3x3_valid_stream_checker conv_check (.*);

  always #2 clk = ~clk;

  // Result side: a random stall after each beat, and a long hold when asked.
  always @(posedge clk) begin : drain_side
    int stall;
    if (!rst && pop && !empty) results_seen <= results_seen + 1;
    if (rst) begin
      pop      <= 1'b0;
      pop_hold <= 0;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      pop_hold  <= LongHold;
      pop       <= 1'b0;
    end else if (pop_hold != 0) begin
      pop_hold <= pop_hold - 1;
      pop      <= (pop_hold == 1);
    end else if (pop && !empty) begin
      stall    = calm ? 0 : $urandom_range(0, 3);
      pop_hold <= stall;
      pop      <= (stall == 0);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no beat accepted for %0d cycles", $time, StallLimit);
        $display("conv3x3_valid_stream regression: fail");
        $finish;
      end
    end
  end

  function automatic pix_t rand_pixel();
    case ($urandom_range(0, 15))
      0:       return PixMin;
      1:       return PixMax;
      2:       return PixMinus;
      3:       return '0;
      default: return pix_t'($urandom);
    endcase
  endfunction

  function automatic logic [CoefBits-1:0] rand_coef_row();
    logic [CoefBits-1:0] row;
    row = '0;
    for (int k = 0; k < KSize; k++) row[k*PixBits +: PixBits] = rand_pixel();
    return row;
  endfunction

  task automatic write_reg(input cfg_index_t idx, input logic [CfgDataBits-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(input pix_t value);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push  <= 1'b1;
    pixel <= value;
    @(posedge clk);
    while (full) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_pixel(rand_pixel());
    push <= 1'b0;
  endtask

  // The block is idle once every expected beat is out and the tail has drained.
  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [WidthBits-1:0]  w_reg;
    logic [HeightBits-1:0] h_reg;
    int w;
    int h;
    int n;
    int sent_random;
    int phases;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Smallest frame with extreme coefficients and pixels.
    write_reg(CfgImageWidth, CfgDataBits'(3));
    write_reg(CfgImageHeight, CfgDataBits'(3));
    write_reg(CfgCoefTop, {PixOne, PixMin, PixMax});
    write_reg(CfgCoefMid, {PixMax, PixMin, PixMinus});
    write_reg(CfgCoefBot, {PixMin, PixMin, pix_t'(0)});
    send_pixel(PixMin);
    send_pixel(PixMax);
    send_pixel('0);
    send_pixel(PixMinus);
    send_pixel(PixOne);
    send_pixel(PixMin);
    send_pixel(PixMax);
    send_pixel(PixMin);
    send_pixel(PixMinus);
    push <= 1'b0;
    settle();

    // Sizes below the minimum are taken as 3x3; coefficient registers at both ends.
    write_reg(CfgImageWidth, CfgDataBits'(0));
    write_reg(CfgImageHeight, CfgDataBits'(1));
    write_reg(CfgCoefTop, {3{PixMin}});
    write_reg(CfgCoefMid, '1);
    write_reg(CfgCoefBot, '0);
    repeat (9) send_pixel(PixMin);
    push <= 1'b0;
    settle();

    // An oversized width is taken as the maximum; this frame also fills
    // every line buffer entry, so later size changes never read stale slots.
    write_reg(CfgCoefBot, rand_coef_row());
    write_reg(CfgImageWidth, CfgDataBits'(127));
    write_reg(CfgImageHeight, CfgDataBits'(3));
    send_random(3 * DefMaxWidth);
    settle();

    // Tallest frame, cut short by lowering the height in the middle of it.
    write_reg(CfgImageWidth, CfgDataBits'(3));
    write_reg(CfgImageHeight, CfgDataBits'(1023));
    send_random(15);
    settle();
    write_reg(CfgImageHeight, CfgDataBits'(5));
    send_random(3);
    settle();

    // Width shrinks mid-row, so the column count is past the new last column.
    write_reg(CfgImageWidth, CfgDataBits'(20));
    write_reg(CfgImageHeight, CfgDataBits'(4));
    send_random(25);
    settle();
    write_reg(CfgImageWidth, CfgDataBits'(4));
    send_random(9);
    settle();

    // Width grows mid-row.
    write_reg(CfgImageWidth, CfgDataBits'(5));
    send_random(7);
    settle();
    write_reg(CfgImageWidth, CfgDataBits'(10));
    send_random(27);
    settle();

    // The result side holds off long enough for the block to fill and stall its input.
    write_reg(CfgImageWidth, CfgDataBits'(16));
    write_reg(CfgImageHeight, CfgDataBits'(16));
    w_reg = WidthBits'(16);
    h_reg = HeightBits'(16);
    calm      <= 1'b1;
    hold_asks <= hold_asks + 1;
    send_random(256);
    settle();

    sent_random = 0;
    phases = 0;
    while (sent_random < RandomItems) begin
      calm <= ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       w_reg = WidthBits'($urandom_range(0, 2));
          1:       w_reg = WidthBits'($urandom_range(65, 127));
          2:       w_reg = WidthBits'(DefMaxWidth);
          default: w_reg = WidthBits'($urandom_range(3, 12));
        endcase
        if ($urandom_range(0, 7) == 0) h_reg = HeightBits'($urandom_range(0, 2));
        else h_reg = HeightBits'($urandom_range(3, 6));
        write_reg(CfgImageWidth, CfgDataBits'(w_reg));
        write_reg(CfgImageHeight, CfgDataBits'(h_reg));
      end
      if ($urandom_range(0, 1) != 0) write_reg(CfgCoefTop, rand_coef_row());
      if ($urandom_range(0, 1) != 0) write_reg(CfgCoefMid, rand_coef_row());
      if ($urandom_range(0, 1) != 0) write_reg(CfgCoefBot, rand_coef_row());

      w = (w_reg < KSize) ? KSize : (w_reg > DefMaxWidth) ? DefMaxWidth : int'(w_reg);
      h = (h_reg < KSize) ? KSize : int'(h_reg);
      n = w * h;
      // Now and then a frame is cut off, so the next setting lands mid-frame.
      if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n - 1);
      send_random(n);
      sent_random += n;
      phases++;
      settle();
    end

    $display("Sent %0d pixels: directed corners, resized frames, a back-pressure frame,",
             pixels_sent);
    $display("and %0d random phases; %0d result beats were checked.", phases, results_seen);
    if (errors == 0 && pending == 0) begin
      $display("conv3x3_valid_stream regression: pass");
    end else begin
      $display("conv3x3_valid_stream regression: fail");
    end
    $finish;
  end

endmodule
